// ===== rtl/core/scatter_gather_put_pairing_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scatter-gather put pairing block
// Each macro expands to one labelled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef SCATTER_GATHER_PUT_PAIRING_ASSERT_SVH
`define SCATTER_GATHER_PUT_PAIRING_ASSERT_SVH

// condition holds at every clock edge outside reset
`define SGPP_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SGPP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/sgpp_pkg.sv =====
// ----------------------------------------------------------------------------
// sgpp_pkg
// Widths, codes and word types shared by the put pairing block.
// ----------------------------------------------------------------------------
package sgpp_pkg;

   // field widths
   localparam int unsigned KIND_W = 2;
   localparam int unsigned ADDR_W = 64;
   localparam int unsigned LEN_W  = 31;
   localparam int unsigned NODE_W = 16;
   localparam int unsigned LEFT_W = 5;

   // list geometry and run limit
   localparam int unsigned DEFAULT_LIST_DEPTH = 16;
   localparam int unsigned MAX_PUTS           = 31;
   localparam int unsigned PUT_CNT_W          = $clog2(MAX_PUTS);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD_LOCAL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_REMOTE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN         = 2'd2;

   // one list segment
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
   } seg_type;

   // input word
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              restart_list;
      logic [ADDR_W-1:0] seg_addr;
      logic [LEN_W-1:0]  seg_len;
      logic [NODE_W-1:0] node_id;
   } req_type;

   // result word
   typedef struct packed {
      logic [NODE_W-1:0] put_node;
      logic [ADDR_W-1:0] dest_addr;
      logic [ADDR_W-1:0] src_addr;
      logic [LEN_W-1:0]  put_len;
      logic              last;
      logic [LEFT_W-1:0] local_left;
      logic [LEFT_W-1:0] remote_left;
   } rsp_type;

endpackage

// ===== rtl/core/sgpp_chan_if.sv =====
// ----------------------------------------------------------------------------
// sgpp_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface sgpp_chan_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/sgpp_seg_mem.sv =====
// ----------------------------------------------------------------------------
// sgpp_seg_mem
// Segment store for one list: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgpp_seg_mem #(
   parameter  int unsigned DEPTH = sgpp_pkg::DEFAULT_LIST_DEPTH,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  sgpp_pkg::seg_type wr_seg,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output sgpp_pkg::seg_type rd_seg
);

   sgpp_pkg::seg_type mem_ff [DEPTH];
   sgpp_pkg::seg_type rd_seg_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_seg;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_seg_ff <= mem_ff[rd_idx];
      end
   end

   assign rd_seg = rd_seg_ff;

endmodule

// ===== rtl/core/scatter_gather_put_pairing.sv =====
// ----------------------------------------------------------------------------
// scatter_gather_put_pairing
// Holds a local and a remote segment list and pairs them into puts.
//
//   channel   dir   payload            purpose
//   req_chan  in    sgpp_pkg::req_type load a segment or start a run
//   rsp_chan  out   sgpp_pkg::rsp_type one put per word, last marks run end
//
// A load is taken in the idle state. A run steps, once per put, through a fetch
// state that reads the segment memories at the current indices and a compute
// state that sizes the put and steps the indices; the input is held for the whole run.
// A put waits in the compute step while the result register is still full.
// Reset clears counters, indices and offsets; segment memories are not
// cleared and their contents are only used below the loaded count.
// ----------------------------------------------------------------------------
`include "scatter_gather_put_pairing_assert.svh"

module scatter_gather_put_pairing #(
   parameter int unsigned LIST_DEPTH = sgpp_pkg::DEFAULT_LIST_DEPTH
) (
   input logic         clock,
   input logic         reset,
   sgpp_chan_if.sink   req_chan,
   sgpp_chan_if.source rsp_chan
);

   localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int unsigned CW    = $clog2(LIST_DEPTH + 1);
   localparam int unsigned EW    = (CW > sgpp_pkg::LEFT_W) ? CW : sgpp_pkg::LEFT_W;
   localparam int unsigned LW    = sgpp_pkg::LEN_W;
   localparam int unsigned AW    = sgpp_pkg::ADDR_W;
   localparam int unsigned PW    = sgpp_pkg::PUT_CNT_W;
   localparam int unsigned LFW   = sgpp_pkg::LEFT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CALC
   } state_type;

   // control registers
   state_type      state_ff, state_in;
   logic [CW-1:0]  l_total_ff, l_total_in, r_total_ff, r_total_in;
   logic [CW-1:0]  l_idx_ff, l_idx_in, r_idx_ff, r_idx_in;
   logic [LW-1:0]  l_off_ff, l_off_in, r_off_ff, r_off_in;
   logic [PW-1:0]  puts_ff, puts_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [sgpp_pkg::NODE_W-1:0] node_ff, node_in;
   sgpp_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // memory ports
   logic              l_wr_en, r_wr_en, rd_en;
   sgpp_pkg::seg_type wr_seg, l_seg, r_seg;
   logic [IDX_W-1:0]  l_wr_idx, r_wr_idx;

   // working signals
   sgpp_pkg::req_type req;
   logic              req_fire, out_free, run_empty;
   logic [CW-1:0]     l_base, r_base;
   logic              l_room, r_room;
   logic [LW-1:0]     l_rem, r_rem, plen, l_sum, r_sum;
   logic              l_done, r_done, step_last;
   logic [CW-1:0]     l_idx_nx, r_idx_nx;
   logic [EW-1:0]     l_left_now, r_left_now, l_left_nx, r_left_nx;
   logic [AW-1:0]     dst_addr, src_addr;

   assign req      = req_chan.payload;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // load path: restart clears the list before the append
   assign l_base   = req.restart_list ? '0 : l_total_ff;
   assign r_base   = req.restart_list ? '0 : r_total_ff;
   assign l_room   = l_base < CW'(LIST_DEPTH);
   assign r_room   = r_base < CW'(LIST_DEPTH);
   assign l_wr_idx = l_base[IDX_W-1:0];
   assign r_wr_idx = r_base[IDX_W-1:0];
   assign wr_seg   = '{addr: req.seg_addr, len: req.seg_len};
   assign rd_en    = (state_ff == ST_FETCH);

   sgpp_seg_mem #(.DEPTH(LIST_DEPTH)) u_local_mem (
      .clock  (clock),
      .wr_en  (l_wr_en),
      .wr_idx (l_wr_idx),
      .wr_seg (wr_seg),
      .rd_en  (rd_en),
      .rd_idx (l_idx_ff[IDX_W-1:0]),
      .rd_seg (l_seg)
   );

   sgpp_seg_mem #(.DEPTH(LIST_DEPTH)) u_remote_mem (
      .clock  (clock),
      .wr_en  (r_wr_en),
      .wr_idx (r_wr_idx),
      .wr_seg (wr_seg),
      .rd_en  (rd_en),
      .rd_idx (r_idx_ff[IDX_W-1:0]),
      .rd_seg (r_seg)
   );

   // put sizing from the segments just read
   assign run_empty = (l_idx_ff >= l_total_ff) || (r_idx_ff >= r_total_ff);
   assign l_rem     = (l_off_ff > l_seg.len) ? '0 : l_seg.len - l_off_ff;
   assign r_rem     = (r_off_ff > r_seg.len) ? '0 : r_seg.len - r_off_ff;
   assign plen      = (l_rem <= r_rem) ? l_rem : r_rem;
   assign l_sum     = l_off_ff + plen;
   assign r_sum     = r_off_ff + plen;
   assign l_done    = l_sum >= l_seg.len;
   assign r_done    = r_sum >= r_seg.len;
   assign l_idx_nx  = l_idx_ff + CW'(l_done);
   assign r_idx_nx  = r_idx_ff + CW'(r_done);
   assign step_last = (l_idx_nx >= l_total_ff) || (r_idx_nx >= r_total_ff)
                      || (puts_ff == PW'(sgpp_pkg::MAX_PUTS - 1));
   assign dst_addr  = r_seg.addr + AW'(r_off_ff);
   assign src_addr  = l_seg.addr + AW'(l_off_ff);

   // segments left, wrapped to the field width
   assign l_left_now = EW'(l_total_ff) - EW'(l_idx_ff);
   assign r_left_now = EW'(r_total_ff) - EW'(r_idx_ff);
   assign l_left_nx  = EW'(l_total_ff) - EW'(l_idx_nx);
   assign r_left_nx  = EW'(r_total_ff) - EW'(r_idx_nx);

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      l_total_in   = l_total_ff;
      r_total_in   = r_total_ff;
      l_idx_in     = l_idx_ff;
      r_idx_in     = r_idx_ff;
      l_off_in     = l_off_ff;
      r_off_in     = r_off_ff;
      puts_in      = puts_ff;
      node_in      = node_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      l_wr_en      = 1'b0;
      r_wr_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req.kind)
                  sgpp_pkg::KIND_LOAD_LOCAL: begin
                     if (req.restart_list) begin
                        l_idx_in = '0;
                        l_off_in = '0;
                     end
                     l_total_in = l_room ? l_base + CW'(1) : l_base;
                     l_wr_en    = l_room;
                  end
                  sgpp_pkg::KIND_LOAD_REMOTE: begin
                     if (req.restart_list) begin
                        r_idx_in = '0;
                        r_off_in = '0;
                     end
                     r_total_in = r_room ? r_base + CW'(1) : r_base;
                     r_wr_en    = r_room;
                  end
                  sgpp_pkg::KIND_RUN: begin
                     node_in  = req.node_id;
                     puts_in  = '0;
                     state_in = ST_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (run_empty) begin
                  // nothing to pair: single empty word
                  rsp_data_in = '{put_node: node_ff, dest_addr: '0, src_addr: '0,
                                  put_len: '0, last: 1'b1,
                                  local_left: l_left_now[LFW-1:0],
                                  remote_left: r_left_now[LFW-1:0]};
                  state_in    = ST_IDLE;
               end else begin
                  rsp_data_in = '{put_node: node_ff, dest_addr: dst_addr,
                                  src_addr: src_addr, put_len: plen,
                                  last: step_last,
                                  local_left: l_left_nx[LFW-1:0],
                                  remote_left: r_left_nx[LFW-1:0]};
                  l_idx_in    = l_idx_nx;
                  r_idx_in    = r_idx_nx;
                  l_off_in    = l_done ? '0 : l_sum;
                  r_off_in    = r_done ? '0 : r_sum;
                  puts_in     = step_last ? '0 : puts_ff + PW'(1);
                  state_in    = step_last ? ST_IDLE : ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         l_total_ff   <= '0;
         r_total_ff   <= '0;
         l_idx_ff     <= '0;
         r_idx_ff     <= '0;
         l_off_ff     <= '0;
         r_off_ff     <= '0;
         puts_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         l_total_ff   <= l_total_in;
         r_total_ff   <= r_total_in;
         l_idx_ff     <= l_idx_in;
         r_idx_ff     <= r_idx_in;
         l_off_ff     <= l_off_in;
         r_off_ff     <= r_off_in;
         puts_ff      <= puts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `SGPP_ASSERT_HOLDS(a_idx_in_list, clock, reset, (l_idx_ff <= l_total_ff) && (r_idx_ff <= r_total_ff), "list index beyond loaded count")
   `SGPP_ASSERT_HOLDS(a_total_in_depth, clock, reset, (l_total_ff <= CW'(LIST_DEPTH)) && (r_total_ff <= CW'(LIST_DEPTH)), "list count beyond depth")
   `SGPP_ASSERT_IMPLIES(a_word_from_calc, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_CALC), "result word raised outside compute step")
   `SGPP_ASSERT_HOLDS(a_put_limit, clock, reset, puts_ff <= PW'(sgpp_pkg::MAX_PUTS - 1), "put count beyond run limit")

endmodule
